/* hdl/pcda_pkg.sv */
// Package for the port counter delta accumulator: shared types and constants.
// Used by the channel interfaces, the record memory, the delta unit and the top level.
package pcda_pkg;

  localparam int NCNT = 7;
  localparam int CW   = 64;
  localparam int LW   = 32;

  // Counter slots within a record.
  localparam int CNT_BYTES_IN  = 0;
  localparam int CNT_PKTS_IN   = 1;
  localparam int CNT_ERRS_IN   = 2;
  localparam int CNT_DROPS_IN  = 3;
  localparam int CNT_BYTES_OUT = 4;
  localparam int CNT_PKTS_OUT  = 5;
  localparam int CNT_ERRS_OUT  = 6;

  // Configuration register indexes.
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_MAX_WIDE   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MAX_NARROW = 2'd1;
  localparam logic [CFG_IW-1:0] REG_START_NAR  = 2'd2;

  localparam logic [CW-1:0] MAX_WIDE_RST   = 64'h0000_0100_0000_0000;
  localparam logic [LW-1:0] MAX_NARROW_RST = 32'h4000_0000;
  localparam logic [LW-1:0] LOW32          = 32'hFFFF_FFFF;

  typedef logic [NCNT-1:0][CW-1:0] cnt_vec_t;

  // One port record as kept in memory.
  typedef struct packed {
    cnt_vec_t          last_raw;
    logic [1:0][LW-1:0] last_low;  // [0] bytes in, [1] bytes out
    cnt_vec_t          total;
  } rec_t;

  typedef struct packed {
    logic [5:0]    port;
    logic [CW-1:0] raw_bytes_in;
    logic [CW-1:0] raw_pkts_in;
    logic [CW-1:0] raw_errs_in;
    logic [CW-1:0] raw_drops_in;
    logic [CW-1:0] raw_bytes_out;
    logic [CW-1:0] raw_pkts_out;
    logic [CW-1:0] raw_errs_out;
  } in_item_t;

  typedef struct packed {
    logic [CW-1:0] total_bytes_in;
    logic [CW-1:0] total_pkts_in;
    logic [CW-1:0] total_errs_in;
    logic [CW-1:0] total_drops_in;
    logic [CW-1:0] total_bytes_out;
    logic [CW-1:0] total_pkts_out;
    logic [CW-1:0] total_errs_out;
    logic          jump_seen;
    logic          first_sample;
    logic          narrow_now;
  } out_item_t;

  // Result of the delta unit.
  typedef struct packed {
    cnt_vec_t           delta;
    logic               jump;
    logic               narrow_next;
    logic [1:0][LW-1:0] new_low;
  } dlt_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ADD
  } st_t;

endpackage

/* hdl/pcda_if.sv */
// Valid/ready channel interfaces for the port counter delta accumulator.
// Depends on pcda_pkg for the item types.
interface pcda_in_if import pcda_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcda_out_if import pcda_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/pcda_rec_mem.sv */
// Per-port record memory: one write port, one read port, registered read data.
// Depends on pcda_pkg for the record type.
module pcda_rec_mem import pcda_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  rec_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output rec_t          rdata
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/pcda_delta.sv */
// Delta unit: counter deltas, narrow-mode byte deltas and the discontinuity check.
// Depends on pcda_pkg.
module pcda_delta import pcda_pkg::*; (
  input  cnt_vec_t      raw,
  input  rec_t          rec,
  input  logic          seen,
  input  logic          narrow,
  input  logic [CW-1:0] max_wide,
  input  logic [LW-1:0] max_narrow,
  output dlt_res_t      res
);

  logic [LW-1:0] lo_in_d;
  logic [LW-1:0] lo_out_d;
  logic [CW-1:0] byte_lim;
  logic [CW-1:0] pkt_lim;

  always_comb begin
    for (int i = 0; i < NCNT; i++) begin
      res.delta[i] = raw[i] - rec.last_raw[i];
    end
    lo_in_d  = raw[CNT_BYTES_IN][LW-1:0] - rec.last_low[0];
    lo_out_d = raw[CNT_BYTES_OUT][LW-1:0] - rec.last_low[1];
    pkt_lim  = {{(CW-LW){1'b0}}, max_narrow};
    if (narrow) begin
      res.delta[CNT_BYTES_IN]  = {{(CW-LW){1'b0}}, lo_in_d};
      res.delta[CNT_BYTES_OUT] = {{(CW-LW){1'b0}}, lo_out_d};
      byte_lim    = pkt_lim;
      res.new_low = {raw[CNT_BYTES_OUT][LW-1:0], raw[CNT_BYTES_IN][LW-1:0]};
    end else begin
      byte_lim    = max_wide;
      res.new_low = rec.last_low;
    end
    // Drop out of narrow mode for good once a byte counter passes 32 bits.
    res.narrow_next = narrow && !(|raw[CNT_BYTES_IN][CW-1:LW])
                             && !(|raw[CNT_BYTES_OUT][CW-1:LW]);
    res.jump = seen && ((res.delta[CNT_BYTES_IN] > byte_lim)
                     || (res.delta[CNT_BYTES_OUT] > byte_lim)
                     || (res.delta[CNT_PKTS_IN] > pkt_lim)
                     || (res.delta[CNT_PKTS_OUT] > pkt_lim));
  end

endmodule

/* hdl/port_counter_delta_accumulator.sv */
// Top level of the port counter delta accumulator.
// Depends on pcda_pkg, pcda_if, pcda_rec_mem and pcda_delta.
//
// Usage:
//   in_ch carries one raw snapshot of a port's seven counters; out_ch returns
//   that port's seven running totals after the update, plus jump_seen,
//   first_sample and narrow_now. Each accepted item gives exactly one result.
//   An item passes through the record memory read, the delta and threshold step
//   and the accumulate/write-back step. Because of the single read-modify-write
//   of the per-port record, the block accepts no new item until the last one
//   has left the write-back step.
//   A finished result sits in the output register; the next item is accepted
//   while it waits. If the receiver still holds the previous result when the
//   next one is ready, the block holds in the write-back cycle until it goes.
//   Reset clears the per-port valid bits, so every record reads as zero until
//   its first sample; no clearing pass is needed. Reset also loads the
//   thresholds and narrow mode with their defaults.
//   cfg_we writes register cfg_index (0 wide limit, 1 narrow limit, 2 start
//   narrow, which also reloads the mode); write only while the block is idle.
//   Ports at or above PORTS leave the state alone and return zero totals.
module port_counter_delta_accumulator import pcda_pkg::*; #(
  parameter int PORTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  pcda_in_if.sink           in_ch,
  pcda_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CW-1:0]     cfg_wdata
);

  // Only 64 port numbers exist, so larger PORTS adds no records.
  localparam int NREC = (PORTS < 64) ? PORTS : 64;
  localparam int IW   = (NREC > 1) ? $clog2(NREC) : 1;

  st_t state_r, state_nxt;

  logic            out_valid_r;
  out_item_t       out_r;
  logic [NREC-1:0] seen_r;
  logic            narrow_r;
  logic [CW-1:0]   max_wide_r;
  logic [LW-1:0]   max_narrow_r;

  // Item held through its delta and write-back steps.
  cnt_vec_t        raw_r;
  logic [IW-1:0]   idx_r;
  logic            inr_r;
  logic            seen_q_r;

  // Results of the delta cycle.
  cnt_vec_t        d_r;
  logic            jump_r;
  rec_t            wrec_r;

  // Handshake and memory control.
  logic            in_accept;
  logic            add_go;
  logic            mem_we;
  logic            mem_re;
  rec_t            mem_rdata;
  rec_t            mem_wdata;

  cnt_vec_t        raw_in;
  logic [IW-1:0]   idx_in;
  logic            inr_in;
  rec_t            rec_rd;
  dlt_res_t        dres;
  cnt_vec_t        tot_new;
  logic            acc;

  assign raw_in[CNT_BYTES_IN]  = in_ch.data.raw_bytes_in;
  assign raw_in[CNT_PKTS_IN]   = in_ch.data.raw_pkts_in;
  assign raw_in[CNT_ERRS_IN]   = in_ch.data.raw_errs_in;
  assign raw_in[CNT_DROPS_IN]  = in_ch.data.raw_drops_in;
  assign raw_in[CNT_BYTES_OUT] = in_ch.data.raw_bytes_out;
  assign raw_in[CNT_PKTS_OUT]  = in_ch.data.raw_pkts_out;
  assign raw_in[CNT_ERRS_OUT]  = in_ch.data.raw_errs_out;

  assign idx_in = in_ch.data.port[IW-1:0];
  assign inr_in = ({26'd0, in_ch.data.port} < 32'(PORTS));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_ADD;
      ST_ADD:  if (add_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ch.ready = 1'b0;
    add_go      = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_DIFF: ;
      ST_ADD:  add_go = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_accept = in_ch.valid && in_ch.ready;
  assign mem_re    = in_accept && inr_in;
  assign mem_we    = add_go && inr_r;

  pcda_rec_mem #(
    .DEPTH (NREC),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx_in),
    .rdata (mem_rdata)
  );

  // A port never sampled reads as an all-zero record.
  assign rec_rd = seen_q_r ? mem_rdata : '0;

  pcda_delta u_delta (
    .raw        (raw_r),
    .rec        (rec_rd),
    .seen       (seen_q_r),
    .narrow     (narrow_r),
    .max_wide   (max_wide_r),
    .max_narrow (max_narrow_r),
    .res        (dres)
  );

  // Accumulate unless first sample or discontinuity.
  assign acc = seen_q_r && !jump_r;

  always_comb begin
    for (int i = 0; i < NCNT; i++) begin
      tot_new[i] = wrec_r.total[i] + (acc ? d_r[i] : '0);
    end
    mem_wdata       = wrec_r;
    mem_wdata.total = tot_new;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      seen_r       <= '0;
      narrow_r     <= 1'b1;
      max_wide_r   <= MAX_WIDE_RST;
      max_narrow_r <= MAX_NARROW_RST;
    end else begin
      state_r <= state_nxt;
      if (add_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        seen_r[idx_r] <= 1'b1;
      end
      if (state_r == ST_DIFF && inr_r) begin
        narrow_r <= dres.narrow_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_WIDE:   max_wide_r   <= cfg_wdata;
          REG_MAX_NARROW: max_narrow_r <= cfg_wdata[LW-1:0];
          REG_START_NAR:  narrow_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      raw_r    <= raw_in;
      idx_r    <= idx_in;
      inr_r    <= inr_in;
      seen_q_r <= inr_in && seen_r[idx_in];
    end
    if (state_r == ST_DIFF) begin
      d_r             <= dres.delta;
      jump_r          <= dres.jump;
      wrec_r.last_raw <= raw_r;
      wrec_r.last_low <= dres.new_low;
      wrec_r.total    <= rec_rd.total;
    end
    if (add_go) begin
      out_r.total_bytes_in  <= inr_r ? tot_new[CNT_BYTES_IN]  : '0;
      out_r.total_pkts_in   <= inr_r ? tot_new[CNT_PKTS_IN]   : '0;
      out_r.total_errs_in   <= inr_r ? tot_new[CNT_ERRS_IN]   : '0;
      out_r.total_drops_in  <= inr_r ? tot_new[CNT_DROPS_IN]  : '0;
      out_r.total_bytes_out <= inr_r ? tot_new[CNT_BYTES_OUT] : '0;
      out_r.total_pkts_out  <= inr_r ? tot_new[CNT_PKTS_OUT]  : '0;
      out_r.total_errs_out  <= inr_r ? tot_new[CNT_ERRS_OUT]  : '0;
      out_r.jump_seen       <= inr_r && jump_r;
      out_r.first_sample    <= inr_r && !seen_q_r;
      out_r.narrow_now      <= narrow_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTHESIS
  a_wr_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_ADD)
    else $error("record write outside write-back cycle");

  a_accept_to_diff: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_DIFF)
    else $error("accepted item did not enter delta cycle");

  a_result_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_ADD))
    else $error("result appeared without write-back cycle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.jump_seen && out_r.first_sample))
    else $error("jump flagged on a first sample");
`endif

endmodule
